@@ sv/dht_pkg.sv @@
`timescale 1ns / 1ps
package dht_pkg;

	// table geometry
	localparam int SLOTS  = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = SLOT_W + 1;

	// fixed field widths
	localparam int CFG_W  = 11;
	localparam int H2_W   = CFG_W + 1;
	localparam int KEY_W  = 64;
	localparam int TAG_W  = 24;
	localparam int DATA_W = 32;
	localparam int STAT_W = 11;
	localparam int IN_W   = 120;
	localparam int OUT_W  = 120;
	localparam int ENT_W  = 2 + TAG_W + DATA_W;

	localparam logic [CFG_W-1:0] TSZ_RESET = 11'd1021;
	localparam logic [CFG_W-1:0] SP_RESET  = 11'd1019;
	localparam logic [H2_W-1:0]  STEP_BASE = 12'd10;
	localparam logic [STAT_W-1:0] HEAVY_LIMIT = 11'd10;

	// register indexes
	localparam logic REG_TSIZE = 1'b0;
	localparam logic REG_PRIME = 1'b1;

	// operations
	localparam logic [1:0] F_INSERT = 2'd0;
	localparam logic [1:0] F_REMOVE = 2'd1;
	localparam logic [1:0] F_LOOKUP = 2'd2;
	localparam logic [1:0] F_NONE   = 2'd3;

	// result status
	localparam logic [1:0] R_DONE = 2'd0;
	localparam logic [1:0] R_DUP  = 2'd1;
	localparam logic [1:0] R_NF   = 2'd2;
	localparam logic [1:0] R_FULL = 2'd3;

	// slot states
	localparam logic [1:0] S_EMPTY = 2'd0;
	localparam logic [1:0] S_LIVE  = 2'd1;
	localparam logic [1:0] S_DEL   = 2'd2;

	typedef enum logic [2:0] {
		CLEAR, IDLE, DIV, STEP, RD, EVAL, HOLD
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic div;
		logic step;
		logic read;
		logic eval;
		logic xfer;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic step_done;
		logic finish;
		logic func_bad;
		logic out_busy;
	} sts_t;

	function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		if (t == 32'd0) t = 32'd1;
		if (t > 32'(SLOTS)) t = 32'(SLOTS);
		return CNT_W'(t);
	endfunction

endpackage

@@ sv/double_hash_open_table_core.sv @@
`timescale 1ns / 1ps
// Flow: accept, key-modulo steps (DIV), step-reduce steps (STEP), then a read and an evaluate per probe
// (1 to table size probes, one memory read port), then the result moves into the output register.
// Throughput: one transaction at a time; unknown ops skip the hash and probe steps.
// Reset: asynchronous active low; a clearing pass marks every slot empty,
// input not accepted until it ends; config writes are taken throughout.
module double_hash_open_table_core
	import dht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // key[63:0], tag[87:64], payload[119:88]
	input  logic [1:0]        s_tuser,   // func[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // slot, found_payload, probes, entry_count,
	                                     // probe_sum, max_probes, over_ten_count, pad
	output logic [1:0]        m_tuser    // status[1:0]
);

	cmd_t cmd;
	sts_t sts;

	dht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_tvalid),
		.in_tready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dht_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_tdata   (s_tdata),
		.in_tuser   (s_tuser),
		.out_tready (m_tready),
		.out_tvalid (m_tvalid),
		.out_tdata  (m_tdata),
		.out_tuser  (m_tuser),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

@@ sv/dht_ctrl.sv @@
`timescale 1ns / 1ps
module dht_ctrl
	import dht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_tvalid,
	output logic in_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CLEAR;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CLEAR: if (sts.clr_done) state_d = IDLE;
			IDLE:  if (in_tvalid) state_d = sts.func_bad ? HOLD : DIV;
			DIV:   if (sts.div_done) state_d = STEP;
			STEP:  if (sts.step_done) state_d = RD;
			RD:    state_d = EVAL;
			EVAL:  state_d = sts.finish ? HOLD : RD;
			HOLD:  if (!sts.out_busy) state_d = IDLE;
			default: state_d = CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_tready = 1'b0;
		unique case (state_q)
			CLEAR: cmd.clear = 1'b1;
			IDLE: begin
				in_tready = 1'b1;
				cmd.load = in_tvalid;
			end
			DIV:  cmd.div = 1'b1;
			STEP: cmd.step = 1'b1;
			RD:   cmd.read = 1'b1;
			EVAL: cmd.eval = 1'b1;
			HOLD: cmd.xfer = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

@@ sv/dht_datapath.sv @@
`timescale 1ns / 1ps
module dht_datapath
	import dht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [IN_W-1:0]   in_tdata,
	input  logic [1:0]        in_tuser,
	input  logic              out_tready,
	output logic              out_tvalid,
	output logic [OUT_W-1:0]  out_tdata,
	output logic [1:0]        out_tuser,
	input  cmd_t              cmd,
	output sts_t              sts
);

	// configuration
	logic [CFG_W-1:0] tsz_q, sp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsz_q <= TSZ_RESET;
			sp_q  <= SP_RESET;
		end else if (cfg_wen) begin
			if (cfg_index == REG_TSIZE) tsz_q <= cfg_wdata;
			else                        sp_q  <= cfg_wdata;
		end
	end

	// slot memory: {state, tag, data}
	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic [SLOT_W-1:0] clr_q;
	logic wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [ENT_W-1:0] wr_data;

	// operation registers
	logic [1:0]        func_q;
	logic [KEY_W-1:0]  key_q;
	logic [TAG_W-1:0]  tag_q;
	logic [DATA_W-1:0] pay_q;
	logic [CNT_W-1:0]  size_q;
	logic [CFG_W-1:0]  prime_q;
	logic [CFG_W-1:0]  r1_q, r2_q, r3_q;
	logic [5:0]        bcnt_q;
	logic [SLOT_W-1:0] pos_q;
	logic [CNT_W-1:0]  i_q;

	// pending result
	logic [1:0]        res_stat_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [DATA_W-1:0] res_found_q;
	logic [CNT_W-1:0]  res_probe_q;

	// statistics
	logic [STAT_W-1:0] live_q, heavy_q;
	logic [CNT_W-1:0]  peak_q;
	logic [31:0]       sum_q;

	// output register
	logic              ov_q;
	logic [OUT_W-1:0]  od_q;
	logic [1:0]        ou_q;

	// remainder steps
	logic [H2_W-1:0] t1, t2, t3, h2, sz12, pr12;
	logic [CFG_W-1:0] r1_n, r2_n, r3_n;
	assign sz12 = H2_W'(size_q);
	assign pr12 = H2_W'(prime_q);
	assign h2   = H2_W'(r2_q) + STEP_BASE;
	assign t1   = {r1_q, key_q[KEY_W-1]};
	assign t2   = {r2_q, key_q[KEY_W-1]};
	assign t3   = {r3_q, h2[4'(H2_W-1) - bcnt_q[3:0]]};
	assign r1_n = (t1 >= sz12) ? CFG_W'(t1 - sz12) : CFG_W'(t1);
	assign r2_n = (t2 >= pr12) ? CFG_W'(t2 - pr12) : CFG_W'(t2);
	assign r3_n = (t3 >= sz12) ? CFG_W'(t3 - sz12) : CFG_W'(t3);

	// next probe position
	logic [CNT_W-1:0] psum;
	logic [SLOT_W-1:0] pos_n;
	assign psum  = CNT_W'(pos_q) + CNT_W'(r3_q);
	assign pos_n = (psum >= size_q) ? SLOT_W'(psum - size_q) : SLOT_W'(psum);

	// probe evaluation
	logic [1:0]        rst;
	logic [TAG_W-1:0]  rtag;
	logic [DATA_W-1:0] rdat;
	logic              tmatch, fin, ins_ok, rem_ok;
	logic [1:0]        f_stat;
	logic [SLOT_W-1:0] f_slot;
	logic [DATA_W-1:0] f_found;
	logic [CNT_W-1:0]  f_probe;
	assign rst    = rd_q[ENT_W-1 -: 2];
	assign rtag   = rd_q[DATA_W +: TAG_W];
	assign rdat   = rd_q[DATA_W-1:0];
	assign tmatch = (rtag == tag_q);

	always_comb begin
		fin = 1'b0;
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		f_stat = R_NF;
		f_slot = pos_q;
		f_found = '0;
		f_probe = i_q;
		if (func_q == F_INSERT) begin
			if (rst != S_LIVE) begin
				fin = 1'b1;
				ins_ok = 1'b1;
				f_stat = R_DONE;
			end else if (tmatch) begin
				fin = 1'b1;
				f_stat = R_DUP;
			end
		end else begin
			if (rst == S_LIVE && tmatch) begin
				fin = 1'b1;
				f_stat = R_DONE;
				if (func_q == F_REMOVE) rem_ok = 1'b1;
				else                    f_found = rdat;
			end else if (rst == S_EMPTY) begin
				fin = 1'b1;
				f_stat = R_NF;
				f_slot = '0;
			end
		end
		// probe budget spent
		if (!fin && (i_q + CNT_W'(1) == size_q)) begin
			fin = 1'b1;
			f_stat = (func_q == F_INSERT) ? R_FULL : R_NF;
			f_slot = '0;
			f_probe = size_q;
		end
	end

	// memory write selection
	always_comb begin
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = {S_LIVE, tag_q, pay_q};
		if (cmd.clear) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.eval && ins_ok) begin
			wr_en = 1'b1;
		end else if (cmd.eval && rem_ok) begin
			wr_en = 1'b1;
			wr_data = {S_DEL, rtag, rdat};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.read) rd_q <= mem[pos_q];
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + SLOT_W'(1);
	end

	// operation sequencing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_tuser;
			key_q   <= in_tdata[KEY_W-1:0];
			tag_q   <= in_tdata[KEY_W +: TAG_W];
			pay_q   <= in_tdata[KEY_W+TAG_W +: DATA_W];
			size_q  <= eff_size(tsz_q);
			prime_q <= (sp_q == '0) ? CFG_W'(1) : sp_q;
			r1_q    <= '0;
			r2_q    <= '0;
			r3_q    <= '0;
			bcnt_q  <= '0;
			res_stat_q  <= R_NF;
			res_slot_q  <= '0;
			res_found_q <= '0;
			res_probe_q <= '0;
		end
		if (cmd.div) begin
			r1_q   <= r1_n;
			r2_q   <= r2_n;
			key_q  <= key_q << 1;
			bcnt_q <= bcnt_q + 6'd1;
		end
		if (cmd.step) begin
			r3_q   <= r3_n;
			bcnt_q <= bcnt_q + 6'd1;
			pos_q  <= SLOT_W'(r1_q);
			i_q    <= '0;
		end
		if (cmd.eval) begin
			if (fin) begin
				res_stat_q  <= f_stat;
				res_slot_q  <= f_slot;
				res_found_q <= f_found;
				res_probe_q <= f_probe;
			end else begin
				pos_q <= pos_n;
				i_q   <= i_q + CNT_W'(1);
			end
		end
	end

	// statistics
	logic [32:0] sum_n;
	assign sum_n = {1'b0, sum_q} + 33'(i_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			heavy_q <= '0;
			peak_q  <= '0;
			sum_q   <= '0;
		end else if (cmd.eval) begin
			if (ins_ok) begin
				live_q <= live_q + STAT_W'(1);
				sum_q  <= sum_n[32] ? '1 : sum_n[31:0];
				if (i_q > peak_q) peak_q <= i_q;
				if (32'(i_q) > 32'(HEAVY_LIMIT) && heavy_q != '1)
					heavy_q <= heavy_q + STAT_W'(1);
			end else if (rem_ok) begin
				live_q <= live_q - STAT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.xfer) ov_q <= 1'b1;
		else if (out_tready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.xfer) begin
			ou_q <= res_stat_q;
			od_q <= {2'b00, STAT_W'(heavy_q), STAT_W'(peak_q), sum_q, live_q,
				STAT_W'(res_probe_q), res_found_q, 10'(res_slot_q)};
		end
	end

	assign out_tvalid = ov_q;
	assign out_tdata  = od_q;
	assign out_tuser  = ou_q;

	assign sts.clr_done  = (clr_q == SLOT_W'(SLOTS - 1));
	assign sts.div_done  = (bcnt_q == 6'(KEY_W - 1));
	assign sts.step_done = (bcnt_q[3:0] == 4'(H2_W - 1));
	assign sts.finish    = fin;
	assign sts.func_bad  = (in_tuser == F_NONE);
	assign sts.out_busy  = ov_q && !out_tready;

	// checks
	a_xfer_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.xfer |-> !(ov_q && !out_tready))
		else $error("result moved into an occupied output register");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (CNT_W'(pos_q) < size_q))
		else $error("probe position outside table");
	a_live_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) <= 32'(SLOTS))
		else $error("live count above slot count");
	a_h1_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (H2_W'(r1_q) < sz12))
		else $error("home slot remainder not reduced");

endmodule

@@ tb/double_hash_open_table_core_tb.sv @@
`timescale 1ns / 1ps
module double_hash_open_table_core_tb;
	import dht_pkg::*;

	// one result transaction, unpacked
	typedef struct {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       found_payload;
		logic [10:0]       probes;
		logic [10:0]       entry_count;
		logic [31:0]       probe_sum;
		logic [10:0]       max_probes;
		logic [10:0]       over_ten_count;
	} hash_result_t;

	// table model and queue of predicted results
	class hash_table_scoreboard;
		logic [1:0]        slot_st [SLOTS];
		logic [TAG_W-1:0]  slot_tg [SLOTS];
		logic [DATA_W-1:0] slot_dt [SLOTS];
		logic [CFG_W-1:0]  tsize;
		logic [CFG_W-1:0]  prime;
		int unsigned       live;
		logic [31:0]       coll_sum;
		int unsigned       coll_peak;
		int unsigned       heavy;
		hash_result_t      pending_q[$];
		int                errors;

		function new();
			tsize = TSZ_RESET;
			prime = SP_RESET;
			live = 0;
			coll_sum = 0;
			coll_peak = 0;
			heavy = 0;
			errors = 0;
			foreach (slot_st[i]) begin
				slot_st[i] = S_EMPTY;
				slot_tg[i] = '0;
				slot_dt[i] = '0;
			end
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] val);
			if (idx == REG_TSIZE) tsize = val;
			else prime = val;
		endfunction

		// predict the result of one accepted operation
		function void note_input(logic [1:0] func, logic [63:0] key, logic [TAG_W-1:0] tag,
				logic [DATA_W-1:0] payload);
			longint unsigned sz, pr, h1, h2, pos, i;
			hash_result_t r;
			sz = (tsize == 0) ? 1 : ((tsize > SLOTS) ? SLOTS : tsize);
			pr = (prime == 0) ? 1 : prime;
			h1 = key % sz;
			h2 = 10 + key % pr;
			r.status = R_NF;
			r.slot = '0;
			r.found_payload = '0;
			r.probes = '0;
			if (func != F_NONE) begin
				r.status = (func == F_INSERT) ? R_FULL : R_NF;
				r.probes = 11'(sz);
				for (i = 0; i < sz; i++) begin
					pos = (h1 + i * h2) % sz;
					if (func == F_INSERT) begin
						if (slot_st[pos] != S_LIVE) begin
							slot_st[pos] = S_LIVE;
							slot_tg[pos] = tag;
							slot_dt[pos] = payload;
							live++;
							r.status = R_DONE;
							r.slot = SLOT_W'(pos);
							r.probes = 11'(i);
							if (coll_sum > 32'hFFFF_FFFF - 32'(i)) coll_sum = 32'hFFFF_FFFF;
							else coll_sum += 32'(i);
							if (i > coll_peak) coll_peak = i;
							if (i > 10 && heavy < 2047) heavy++;
							break;
						end
						if (slot_tg[pos] == tag) begin
							r.status = R_DUP;
							r.slot = SLOT_W'(pos);
							r.probes = 11'(i);
							break;
						end
					end else begin
						if (slot_st[pos] == S_LIVE && slot_tg[pos] == tag) begin
							r.status = R_DONE;
							r.slot = SLOT_W'(pos);
							r.probes = 11'(i);
							if (func == F_REMOVE) begin
								slot_st[pos] = S_DEL;
								live--;
							end else begin
								r.found_payload = slot_dt[pos];
							end
							break;
						end
						if (slot_st[pos] == S_EMPTY) begin
							r.status = R_NF;
							r.probes = 11'(i);
							break;
						end
					end
				end
			end
			r.entry_count = 11'(live);
			r.probe_sum = coll_sum;
			r.max_probes = 11'(coll_peak);
			r.over_ten_count = 11'(heavy);
			pending_q.push_back(r);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
			hash_result_t e;
			if (pending_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (user != e.status) begin
				$error("status: expected %0d, got %0d", e.status, user); errors++;
			end
			if (data[9:0] != e.slot) begin
				$error("slot: expected %0d, got %0d", e.slot, data[9:0]); errors++;
			end
			if (data[41:10] != e.found_payload) begin
				$error("found_payload: expected %h, got %h", e.found_payload, data[41:10]);
				errors++;
			end
			if (data[52:42] != e.probes) begin
				$error("probes: expected %0d, got %0d", e.probes, data[52:42]); errors++;
			end
			if (data[63:53] != e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, data[63:53]);
				errors++;
			end
			if (data[95:64] != e.probe_sum) begin
				$error("probe_sum: expected %0d, got %0d", e.probe_sum, data[95:64]); errors++;
			end
			if (data[106:96] != e.max_probes) begin
				$error("max_probes: expected %0d, got %0d", e.max_probes, data[106:96]);
				errors++;
			end
			if (data[117:107] != e.over_ten_count) begin
				$error("over_ten_count: expected %0d, got %0d", e.over_ten_count,
					data[117:107]);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;

	hash_table_scoreboard table_sb = new();
	bit long_hold = 1'b0;
	logic [63:0] key_pool [16];
	logic [TAG_W-1:0] tag_pool [8];

	double_hash_open_table_core DUT (.*);

	always #5 clk = ~clk;

	initial begin
		#200_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stall per transaction, one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = long_hold ? 3000 : $urandom_range(0, 3);
			long_hold = 1'b0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			table_sb.check_result(m_tdata, m_tuser);
		end
	end

	task automatic send_op(logic [1:0] func, logic [63:0] key, logic [TAG_W-1:0] tag,
			logic [DATA_W-1:0] payload);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {payload, tag, key};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		table_sb.note_input(func, key, tag, payload);
	endtask

	// wait for every predicted result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (table_sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_tables(logic [CFG_W-1:0] tsize, logic [CFG_W-1:0] prime);
		cfg_wen <= 1'b1;
		cfg_index <= REG_TSIZE;
		cfg_wdata <= tsize;
		@(posedge clk);
		cfg_index <= REG_PRIME;
		cfg_wdata <= prime;
		@(posedge clk);
		cfg_wen <= 1'b0;
		table_sb.write_reg(REG_TSIZE, tsize);
		table_sb.write_reg(REG_PRIME, prime);
	endtask

	// random operation biased toward a small set of keys and tags so entries collide
	task automatic send_random();
		int pick;
		logic [1:0] func;
		logic [63:0] key;
		logic [TAG_W-1:0] tag;
		pick = $urandom_range(0, 99);
		func = (pick < 45) ? F_INSERT : (pick < 65) ? F_REMOVE : (pick < 95) ? F_LOOKUP : F_NONE;
		key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 15)]
			: {$urandom, $urandom};
		tag = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 7)] : TAG_W'($urandom);
		send_op(func, key, tag, $urandom);
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [10] = '{7, 13, 31, 2047, 1024, 1021, 97, 3, 0, 5};
		logic [CFG_W-1:0] primes [10] = '{5, 11, 29, 0, 1, 1019, 89, 2, 2047, 3};
		foreach (key_pool[i]) key_pool[i] = (i < 8) ? 64'($urandom_range(0, 40))
			: {$urandom, $urandom};
		foreach (tag_pool[i]) tag_pool[i] = (i < 4) ? TAG_W'(i) : TAG_W'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default geometry
		send_op(F_INSERT, 64'd0, 24'd0, 32'd0);
		send_op(F_INSERT, '1, '1, '1);
		send_op(F_INSERT, '1, '1, 32'h1234_5678);
		send_op(F_LOOKUP, '1, '1, '0);
		send_op(F_LOOKUP, 64'd0, 24'd7, '0);
		send_op(F_REMOVE, '1, '1, '0);
		send_op(F_REMOVE, '1, '1, '0);
		send_op(F_LOOKUP, '1, '1, '0);
		send_op(F_NONE, 64'd5, 24'd1, '1);
		send_op(F_INSERT, 64'd5, 24'd1, 32'hA5A5_A5A5);
		send_op(F_INSERT, 64'd5, 24'd2, 32'h5A5A_5A5A);
		send_op(F_INSERT, 64'd5, 24'd3, 32'hDEAD_BEEF);
		send_op(F_LOOKUP, 64'd5, 24'd3, '0);
		drain();

		// directed: tiny table fills, remove and insert on a full table, resize with entries kept
		set_tables(11'd3, 11'd2);
		repeat (4) send_op(F_INSERT, 64'd9, TAG_W'($urandom), $urandom);
		send_op(F_LOOKUP, 64'd9, 24'hABCDEF, '0);
		send_op(F_REMOVE, 64'd9, 24'd0, '0);
		send_op(F_INSERT, 64'd9, 24'd77, 32'hCAFE_F00D);
		drain();
		set_tables(11'd0, 11'd0);
		send_op(F_INSERT, 64'd3, 24'd5, 32'd1);
		send_op(F_INSERT, 64'd3, 24'd6, 32'd2);
		send_op(F_LOOKUP, 64'd3, 24'd5, '0);
		drain();

		// random phases across geometries
		foreach (sizes[p]) begin
			set_tables(sizes[p], primes[p]);
			for (int n = 0; n < 170; n++) begin
				if (p == 1 && n == 60) long_hold = 1'b1;
				if (n == 100) drain();
				send_random();
			end
			drain();
		end

		while (table_sb.pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (table_sb.errors == 0 && table_sb.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dht_pkg.sv
sv/dht_ctrl.sv
sv/dht_datapath.sv
sv/double_hash_open_table_core.sv
tb/double_hash_open_table_core_tb.sv
